// File: hdl/aarm_pkg.sv
// shared constants, types and functions for the axis-angle rotation matrix core
// no dependencies
package aarm_pkg;

  localparam int CordicIterations = 16;
  localparam int OutFracBits = 14;
  localparam int QW = 36;                 // q30 datapath width (holds +-2pi)
  localparam int NormBits = 34;           // n2 << 32 fits 66 bits, root 33 bits
  localparam int RootBits = 34;
  localparam int DivBits = 31;            // quotient bits of |v| * 2^46 / r

  localparam logic signed [QW-1:0] OneQ30 = 36'sd1073741824;
  localparam logic signed [QW-1:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [QW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [QW-1:0] TwoPiQ30 = 36'sd6746518852;
  localparam logic signed [QW-1:0] GainInvQ30 = 36'sd652032874;

  function automatic logic signed [QW-1:0] atan_q30(input logic [5:0] i);
    logic signed [QW-1:0] v;
    unique case (i)
      6'd0: v = 36'sd843314856;
      6'd1: v = 36'sd497837829;
      6'd2: v = 36'sd263043837;
      6'd3: v = 36'sd133525158;
      6'd4: v = 36'sd67021686;
      6'd5: v = 36'sd33543515;
      6'd6: v = 36'sd16775850;
      6'd7: v = 36'sd8388437;
      6'd8: v = 36'sd4194282;
      6'd9: v = 36'sd2097149;
      default: begin
        if (i < 6'd30) v = (36'sd1 <<< (6'd30 - i)) - 36'sd1;
        else v = '0;
      end
    endcase
    return v;
  endfunction

  // cordic working set: vector x, y and residual angle a
  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] a;
  } cordic_t;

  // one sqrt working set, partial root is scaled by the current digit weight
  typedef struct packed {
    logic [67:0] rem;
    logic [67:0] root;
  } sqrt_t;

  // item state carried through the chain
  typedef struct packed {
    logic valid;
    logic zero;
    logic flip;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic sx;
    logic sy;
    logic sz;
    cordic_t cd;
    sqrt_t sq;
  } item_t;

endpackage

// File: hdl/aarm_cell.sv
// one chain cell: a cordic micro-rotation and/or one square-root digit
// depends on aarm_pkg
module aarm_cell #(
  parameter int Index = 0,
  parameter int Iterations = aarm_pkg::CordicIterations
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  aarm_pkg::item_t din,
  output aarm_pkg::item_t dout
);

  localparam logic [5:0] Shift = 6'(Index);
  localparam int SqIdx = (Index < 34) ? 33 - Index : 0;
  localparam bit SqOn = (Index < 34);

  aarm_pkg::item_t nxt;
  logic [67:0] trial;
  logic [67:0] bitv;

  always_comb begin
    nxt = din;
    if (Index < Iterations && Index < 32) begin
      if (!din.cd.a[aarm_pkg::QW-1]) begin
        nxt.cd.x = din.cd.x - (din.cd.y >>> Shift);
        nxt.cd.y = din.cd.y + (din.cd.x >>> Shift);
        nxt.cd.a = din.cd.a - aarm_pkg::atan_q30(Shift);
      end else begin
        nxt.cd.x = din.cd.x + (din.cd.y >>> Shift);
        nxt.cd.y = din.cd.y - (din.cd.x >>> Shift);
        nxt.cd.a = din.cd.a + aarm_pkg::atan_q30(Shift);
      end
    end
    bitv = 68'd1 << (2 * SqIdx);
    trial = din.sq.root + bitv;
    if (SqOn) begin
      if (din.sq.rem >= trial) begin
        nxt.sq.rem = din.sq.rem - trial;
        nxt.sq.root = (din.sq.root >> 1) + bitv;
      end else begin
        nxt.sq.root = din.sq.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.zero <= nxt.zero;
      dout.flip <= nxt.flip;
      dout.ax <= nxt.ax;
      dout.ay <= nxt.ay;
      dout.az <= nxt.az;
      dout.sx <= nxt.sx;
      dout.sy <= nxt.sy;
      dout.sz <= nxt.sz;
      dout.cd <= nxt.cd;
      dout.sq <= nxt.sq;
    end
  end

endmodule

// File: hdl/aarm_div.sv
// restoring divider chain: three unit components, one quotient bit per stage
// depends on aarm_pkg
module aarm_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [15:0] num_x,
  input  logic [15:0] num_y,
  input  logic [15:0] num_z,
  input  logic [aarm_pkg::RootBits-1:0] den,
  output logic out_valid,
  output logic [aarm_pkg::DivBits-1:0] qx,
  output logic [aarm_pkg::DivBits-1:0] qy,
  output logic [aarm_pkg::DivBits-1:0] qz
);

  localparam int N = aarm_pkg::DivBits;
  // dividend = mag << 46 (62 bits); quotient < 2^31 since r >= mag * 2^16
  localparam int RW = 36;

  logic v [N+1];
  logic [RW-1:0] rx [N+1];
  logic [RW-1:0] ry [N+1];
  logic [RW-1:0] rz [N+1];
  logic [N-1:0] ax [N+1];
  logic [N-1:0] ay [N+1];
  logic [N-1:0] az [N+1];
  logic [61:0] nx [N+1];
  logic [61:0] ny [N+1];
  logic [61:0] nz [N+1];
  logic [aarm_pkg::RootBits-1:0] dd [N+1];

  // remainder starts as the upper 31 dividend bits, which are below r
  always_comb begin
    v[0] = in_valid;
    rx[0] = RW'({num_x, 15'd0});
    ry[0] = RW'({num_y, 15'd0});
    rz[0] = RW'({num_z, 15'd0});
    ax[0] = '0;
    ay[0] = '0;
    az[0] = '0;
    nx[0] = {num_x, 46'd0};
    ny[0] = {num_y, 46'd0};
    nz[0] = {num_z, 46'd0};
    dd[0] = den;
  end

  for (genvar g = 0; g < N; g++) begin : g_st
    localparam int B = 30 - g;
    logic [RW-1:0] tx, ty, tz;
    // shift in the next lower dividend bit
    always_comb begin
      tx = {rx[g][RW-2:0], 1'b0} | RW'(nx[g][B]);
      ty = {ry[g][RW-2:0], 1'b0} | RW'(ny[g][B]);
      tz = {rz[g][RW-2:0], 1'b0} | RW'(nz[g][B]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
      if (en) begin
        dd[g+1] <= dd[g];
        nx[g+1] <= nx[g];
        ny[g+1] <= ny[g];
        nz[g+1] <= nz[g];
        if (tx >= RW'(dd[g])) begin
          rx[g+1] <= tx - RW'(dd[g]);
          ax[g+1] <= {ax[g][N-2:0], 1'b1};
        end else begin
          rx[g+1] <= tx;
          ax[g+1] <= {ax[g][N-2:0], 1'b0};
        end
        if (ty >= RW'(dd[g])) begin
          ry[g+1] <= ty - RW'(dd[g]);
          ay[g+1] <= {ay[g][N-2:0], 1'b1};
        end else begin
          ry[g+1] <= ty;
          ay[g+1] <= {ay[g][N-2:0], 1'b0};
        end
        if (tz >= RW'(dd[g])) begin
          rz[g+1] <= tz - RW'(dd[g]);
          az[g+1] <= {az[g][N-2:0], 1'b1};
        end else begin
          rz[g+1] <= tz;
          az[g+1] <= {az[g][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign qx = ax[N];
  assign qy = ay[N];
  assign qz = az[N];

endmodule

// File: hdl/axis_angle_rotation_matrix_core.sv
// top level: axis-angle to 3x3 rotation matrix, rodrigues formula, fixed point
// depends on aarm_pkg, aarm_cell, aarm_div
//
// input channel: in_valid / in_ready with angle (q4.20 rad) and axis_x/y/z.
// output channel: out_valid / out_ready with m00..m22 (q2.14) and zero_axis.
// one item in, one item out, in order. a new item may enter every cycle while
// in_ready is high. path from the accepting edge to out_valid: the square
// register loads at the accepting edge, then 34 chain cells (one root digit
// per cell, a cordic rotation per cell below CORDIC_ITERATIONS), 31 divider
// stages for the unit axis, 3 product and sum stages and the output register.
// throughput one item per cycle while the output is not stalled.
// the whole pipeline advances only when the output register is empty or is
// being taken, so a stalled receiver freezes it with nothing lost; in_ready
// then falls.
// a zero axis gives the identity and zero_axis high.
// reset clears all valid flags; no clearing pass.
//
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_ITERATIONS = aarm_pkg::CordicIterations,
  parameter int OUT_FRAC_BITS = aarm_pkg::OutFracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [23:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic zero_axis
);

  localparam int QW = aarm_pkg::QW;
  localparam int Cells = 34;
  localparam int Sh = (OUT_FRAC_BITS >= 30) ? 0 : 30 - OUT_FRAC_BITS;
  localparam int PW = 2 * QW;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // ---- entry: range reduction, axis magnitude, n2
  aarm_pkg::item_t chain [Cells+1];
  logic signed [QW-1:0] a0, a1, a2;
  logic fl;
  logic [15:0] mx, my, mz;
  logic [33:0] n2;

  always_comb begin
    a0 = QW'(angle) <<< 10;
    if (a0 > aarm_pkg::PiQ30) a1 = a0 - aarm_pkg::TwoPiQ30;
    else if (a0 < -aarm_pkg::PiQ30) a1 = a0 + aarm_pkg::TwoPiQ30;
    else a1 = a0;
    fl = 1'b1;
    if (a1 > aarm_pkg::HalfPiQ30) a2 = a1 - aarm_pkg::PiQ30;
    else if (a1 < -aarm_pkg::HalfPiQ30) a2 = a1 + aarm_pkg::PiQ30;
    else begin
      a2 = a1;
      fl = 1'b0;
    end
    mx = axis_x[15] ? 16'(-axis_x) : axis_x;
    my = axis_y[15] ? 16'(-axis_y) : axis_y;
    mz = axis_z[15] ? 16'(-axis_z) : axis_z;
  end

  // squares registered before the sum
  logic [31:0] sqx, sqy, sqz;
  aarm_pkg::item_t pre;
  always_ff @(posedge clk) begin
    if (rst) pre.valid <= 1'b0;
    else if (en) pre.valid <= in_valid;
    if (en) begin
      sqx <= mx * mx;
      sqy <= my * my;
      sqz <= mz * mz;
      pre.zero <= 1'b0;
      pre.flip <= fl;
      pre.ax <= mx;
      pre.ay <= my;
      pre.az <= mz;
      pre.sx <= axis_x[15];
      pre.sy <= axis_y[15];
      pre.sz <= axis_z[15];
      pre.cd.x <= aarm_pkg::GainInvQ30;
      pre.cd.y <= '0;
      pre.cd.a <= a2;
      pre.sq <= '0;
    end
  end

  always_comb begin
    n2 = 34'(sqx) + 34'(sqy) + 34'(sqz);
    chain[0] = pre;
    chain[0].zero = (n2 == '0);
    chain[0].sq.rem = {2'b0, n2, 32'd0};
    chain[0].sq.root = '0;
  end

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    if (g < CORDIC_ITERATIONS || g < 34) begin : g_c
      aarm_cell #(.Index(g), .Iterations(CORDIC_ITERATIONS)) u_cell (
        .clk(clk), .rst(rst), .en(en), .din(chain[g]), .dout(chain[g+1])
      );
    end
  end

  // extra cordic iterations beyond the root digits
  localparam int Extra = (CORDIC_ITERATIONS > Cells) ?
      ((CORDIC_ITERATIONS > 32) ? 32 - Cells : CORDIC_ITERATIONS - Cells) : 0;
  aarm_pkg::item_t ext [Extra+1];
  assign ext[0] = chain[Cells];
  for (genvar g = 0; g < Extra; g++) begin : g_ext
    aarm_cell #(.Index(Cells + g), .Iterations(CORDIC_ITERATIONS)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(ext[g]), .dout(ext[g+1])
    );
  end
  aarm_pkg::item_t ce;
  assign ce = ext[Extra];

  // ---- divider for unit axis, side data delayed alongside
  localparam int DN = aarm_pkg::DivBits;
  logic dv;
  logic [DN-1:0] qx, qy, qz;
  aarm_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(ce.valid),
    .num_x(ce.ax), .num_y(ce.ay), .num_z(ce.az),
    .den(ce.sq.root == '0 ? aarm_pkg::RootBits'(1) :
         ce.sq.root[aarm_pkg::RootBits-1:0]),
    .out_valid(dv), .qx(qx), .qy(qy), .qz(qz)
  );

  logic signed [QW-1:0] dc [DN+1];
  logic signed [QW-1:0] ds [DN+1];
  logic [3:0] df [DN+1];
  always_comb begin
    dc[0] = ce.flip ? -ce.cd.x : ce.cd.x;
    ds[0] = ce.flip ? -ce.cd.y : ce.cd.y;
    df[0] = {ce.zero, ce.sx, ce.sy, ce.sz};
  end
  for (genvar g = 0; g < DN; g++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        dc[g+1] <= dc[g];
        ds[g+1] <= ds[g];
        df[g+1] <= df[g];
      end
    end
  end

  // ---- products
  logic signed [QW-1:0] ux, uy, uz, c1, t1, s1;
  logic z1;
  always_comb begin
    ux = df[DN][2] ? -QW'(qx) : QW'(qx);
    uy = df[DN][1] ? -QW'(qy) : QW'(qy);
    uz = df[DN][0] ? -QW'(qz) : QW'(qz);
    c1 = dc[DN];
    s1 = ds[DN];
    t1 = aarm_pkg::OneQ30 - dc[DN];
    z1 = df[DN][3];
  end

  // stage p1: pair products and sine products
  logic signed [QW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, xs, ys, zs, c2, t2;
  logic v2, z2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= dv;
    if (en) begin
      pxx <= QW'((PW'(ux) * PW'(ux)) >>> 30);
      pyy <= QW'((PW'(uy) * PW'(uy)) >>> 30);
      pzz <= QW'((PW'(uz) * PW'(uz)) >>> 30);
      pxy <= QW'((PW'(ux) * PW'(uy)) >>> 30);
      pxz <= QW'((PW'(ux) * PW'(uz)) >>> 30);
      pyz <= QW'((PW'(uy) * PW'(uz)) >>> 30);
      xs <= QW'((PW'(ux) * PW'(s1)) >>> 30);
      ys <= QW'((PW'(uy) * PW'(s1)) >>> 30);
      zs <= QW'((PW'(uz) * PW'(s1)) >>> 30);
      c2 <= c1;
      t2 <= t1;
      z2 <= z1;
    end
  end

  // stage p2: times t
  logic signed [QW-1:0] qxx, qyy, qzz, qxy, qxz, qyz, xs3, ys3, zs3, c3;
  logic v3, z3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      qxx <= QW'((PW'(pxx) * PW'(t2)) >>> 30);
      qyy <= QW'((PW'(pyy) * PW'(t2)) >>> 30);
      qzz <= QW'((PW'(pzz) * PW'(t2)) >>> 30);
      qxy <= QW'((PW'(pxy) * PW'(t2)) >>> 30);
      qxz <= QW'((PW'(pxz) * PW'(t2)) >>> 30);
      qyz <= QW'((PW'(pyz) * PW'(t2)) >>> 30);
      xs3 <= xs;
      ys3 <= ys;
      zs3 <= zs;
      c3 <= c2;
      z3 <= z2;
    end
  end

  // stage p3: sums
  logic signed [QW:0] e [9];
  logic v4, z4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      e[0] <= (QW+1)'(c3) + (QW+1)'(qxx);
      e[1] <= (QW+1)'(qxy) - (QW+1)'(zs3);
      e[2] <= (QW+1)'(qxz) + (QW+1)'(ys3);
      e[3] <= (QW+1)'(qxy) + (QW+1)'(zs3);
      e[4] <= (QW+1)'(c3) + (QW+1)'(qyy);
      e[5] <= (QW+1)'(qyz) - (QW+1)'(xs3);
      e[6] <= (QW+1)'(qxz) - (QW+1)'(ys3);
      e[7] <= (QW+1)'(qyz) + (QW+1)'(xs3);
      e[8] <= (QW+1)'(c3) + (QW+1)'(qzz);
      z4 <= z3;
    end
  end

  // output rounding, saturation and register
  function automatic logic signed [15:0] to_out(input logic signed [QW:0] v);
    logic signed [QW+1:0] r;
    r = (QW+2)'(v);
    if (Sh > 0) r = (r + ((QW+2)'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return -16'sh8000;
    return 16'(r);
  endfunction

  logic signed [15:0] one_out;
  assign one_out = to_out((QW+1)'(aarm_pkg::OneQ30));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v4;
    if (en) begin
      m00 <= z4 ? one_out : to_out(e[0]);
      m01 <= z4 ? '0 : to_out(e[1]);
      m02 <= z4 ? '0 : to_out(e[2]);
      m10 <= z4 ? '0 : to_out(e[3]);
      m11 <= z4 ? one_out : to_out(e[4]);
      m12 <= z4 ? '0 : to_out(e[5]);
      m20 <= z4 ? '0 : to_out(e[6]);
      m21 <= z4 ? '0 : to_out(e[7]);
      m22 <= z4 ? one_out : to_out(e[8]);
      zero_axis <= z4;
    end
  end

endmodule

// File: hdl/aarm_checker.sv
// port-level checks for the rotation matrix core
// depends on axis_angle_rotation_matrix_core
module aarm_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] m01,
  input logic signed [15:0] m00,
  input logic zero_axis
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m00))
    else $error("output changed while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_axis |-> m01 == 16'sd0)
    else $error("zero axis gave nonzero off-diagonal");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .m01(m01), .m00(m00),
  .zero_axis(zero_axis)
);

// File: tb/tb_axis_angle_rotation_matrix_core.sv
// testbench for the axis-angle rotation matrix core: predicts each matrix in q30
// integer arithmetic and checks every output item in order
// depends on aarm_pkg and axis_angle_rotation_matrix_core
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix_core;

  typedef struct packed {
    logic [8:0][15:0] m;
    logic zero;
  } matrix_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [23:0] angle = '0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic zero_axis;

  matrix_t expected_q[$];
  int mismatches = 0;
  int matrices_seen = 0;
  int items_sent = 0;
  bit no_idle = 0;

  axis_angle_rotation_matrix_core dut (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint arctan_q30(int i);
    longint head[10] = '{843314856, 497837829, 263043837, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return head[i];
    if (i < 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  function automatic logic [15:0] round_sat(longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_axis(longint v, longint unsigned r);
    longint unsigned mag;
    longint q;
    mag = v < 0 ? -v : v;
    q = (mag << 46) / r;
    return v < 0 ? -q : q;
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [23:0] ang,
      logic signed [15:0] vx, logic signed [15:0] vy, logic signed [15:0] vz);
    matrix_t res;
    longint a, ax, ay, az, cx, cy, dx, dy, c, s, t, x, y, z;
    longint xyt, xzt, yzt, xs, ys, zs;
    longint mm[9];
    longint unsigned n2, r;
    bit flip;
    a = longint'(ang) * 1024;
    ax = vx;
    ay = vy;
    az = vz;
    n2 = ax * ax + ay * ay + az * az;
    if (n2 == 0) begin
      for (int k = 0; k < 9; k++) res.m[8 - k] = (k % 4 == 0) ? 16'sd16384 : 16'sd0;
      res.zero = 1;
      return res;
    end
    if (a > aarm_pkg::PiQ30) a -= aarm_pkg::TwoPiQ30;
    else if (a < -aarm_pkg::PiQ30) a += aarm_pkg::TwoPiQ30;
    flip = 0;
    if (a > aarm_pkg::HalfPiQ30) begin
      a -= aarm_pkg::PiQ30;
      flip = 1;
    end else if (a < -aarm_pkg::HalfPiQ30) begin
      a += aarm_pkg::PiQ30;
      flip = 1;
    end
    cx = aarm_pkg::GainInvQ30;
    cy = 0;
    for (int i = 0; i < aarm_pkg::CordicIterations && i < 32; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (a >= 0) begin
        cx -= dx;
        cy += dy;
        a -= arctan_q30(i);
      end else begin
        cx += dx;
        cy -= dy;
        a += arctan_q30(i);
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
    t = aarm_pkg::OneQ30 - c;
    r = int_sqrt(n2 << 32);
    x = unit_axis(ax, r);
    y = unit_axis(ay, r);
    z = unit_axis(az, r);
    xyt = q30_mul(q30_mul(x, y), t);
    xzt = q30_mul(q30_mul(x, z), t);
    yzt = q30_mul(q30_mul(y, z), t);
    xs = q30_mul(x, s);
    ys = q30_mul(y, s);
    zs = q30_mul(z, s);
    mm[0] = c + q30_mul(q30_mul(x, x), t);
    mm[1] = xyt - zs;
    mm[2] = xzt + ys;
    mm[3] = xyt + zs;
    mm[4] = c + q30_mul(q30_mul(y, y), t);
    mm[5] = yzt - xs;
    mm[6] = xzt - ys;
    mm[7] = yzt + xs;
    mm[8] = c + q30_mul(q30_mul(z, z), t);
    for (int k = 0; k < 9; k++) res.m[8 - k] = round_sat(mm[k]);
    res.zero = 0;
    return res;
  endfunction

  task automatic send_item(logic signed [23:0] ang, logic signed [15:0] vx,
      logic signed [15:0] vy, logic signed [15:0] vz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    angle <= ang;
    axis_x <= vx;
    axis_y <= vy;
    axis_z <= vz;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(rotation_matrix(ang, vx, vy, vz));
    items_sent++;
  endtask

  // receiver: random stalls, compare every accepted item
  initial begin
    matrix_t got, want;
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      got.m = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
      got.zero = zero_axis;
      matrices_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item %0d", matrices_seen);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got.m[8 - k] !== want.m[8 - k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item %0d m%0d%0d: expected %0d got %0d", matrices_seen,
                       k / 3, k % 3, $signed(want.m[8 - k]), $signed(got.m[8 - k]));
          end
        if (got.zero !== want.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item %0d zero_axis: expected %b got %b", matrices_seen,
                     want.zero, got.zero);
        end
      end
    end
  end

  task automatic drain_outputs();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    logic signed [23:0] angs[8] = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd3294198,
                                    -24'sd3294198, 24'sd1647099, 24'sd1, -24'sd1};
    foreach (angs[i]) send_item(angs[i], 16'sd100, -16'sd50, 16'sd25);
    send_item(24'sd1000000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(24'sd1000000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(24'sh7FFFFF, 16'sh8000, 16'sh7FFF, 16'sd0);
    send_item(-24'sd2000000, 16'sd1, 16'sd0, 16'sd0);
    send_item(24'sd2000000, 16'sd0, -16'sd1, 16'sd0);
    send_item(24'sd500000, 16'sd0, 16'sd0, 16'sh8000);
    send_item(24'sd3000000, 16'sd0, 16'sd0, 16'sd0);
    send_item(24'sh800000, 16'sd0, 16'sd0, 16'sd0);
    send_item(24'sd5000000, 16'sd3, 16'sd4, 16'sd0);
    send_item(-24'sd5000000, 16'sh7FFF, 16'sd1, 16'sh8000);
  endtask

  task automatic test_pause_until_drained();
    send_item(24'sd123456, 16'sd7, 16'sd8, 16'sd9);
    drain_outputs();
    send_item(-24'sd654321, -16'sd9, 16'sd8, -16'sd7);
  endtask

  task automatic test_back_to_back();
    no_idle = 1;
    for (int i = 0; i < 150; i++)
      send_item(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    no_idle = 0;
  endtask

  task automatic test_random(int count);
    logic signed [15:0] v[3];
    for (int i = 0; i < count; i++) begin
      foreach (v[j]) begin
        case ($urandom_range(0, 3))
          0: v[j] = 16'(int'($urandom_range(0, 15)) - 8);
          1: v[j] = 0;
          default: v[j] = 16'($urandom);
        endcase
      end
      send_item(24'($urandom), v[0], v[1], v[2]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    test_extremes();
    test_pause_until_drained();
    test_back_to_back();
    test_random(1030);
    drain_outputs();
    repeat (200) @(posedge clk);
    $display("sent %0d angle-axis items, checked %0d matrices, including zero axes,",
             items_sent, matrices_seen);
    $display("angle wrap and fold cases, saturation and random stalls on both sides");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d items outstanding", mismatches, expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
